// File: hdl/tlbfr_pkg.sv
// shared types and constants of the fifo-replacement translation buffer
// no dependencies; imported by the interfaces, the cell, the top level and the checker
package tlbfr_pkg;

    localparam int OP_W        = 2;
    localparam int PAGE_W      = 8;
    localparam int FRAME_W     = 16;
    localparam int OCC_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    typedef struct packed {
        logic match_all;
        logic match_page;
        logic shift;
    } t_mode;

    typedef struct packed {
        logic                tok;
        logic                found;
        logic [FRAME_W-1:0]  frame;
    } t_link;

    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [FRAME_W-1:0]  frame;
    } t_pair;

endpackage

// File: hdl/tlbfr_if.sv
// valid/ready channel interfaces for request and response transfers
// depends on tlbfr_pkg for the field widths
interface tlbfr_in_if import tlbfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [PAGE_W-1:0]   page_number;
    logic [FRAME_W-1:0]  frame_number;

    modport source (output valid, output operation, output page_number, output frame_number,
                    input ready);
    modport sink   (input valid, input operation, input page_number, input frame_number,
                    output ready);
endinterface

interface tlbfr_out_if import tlbfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic [FRAME_W-1:0]  frame_out;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output hit, output frame_out, output occupancy,
                    input ready);
    modport sink   (input valid, input hit, input frame_out, input occupancy,
                    output ready);
endinterface

// File: hdl/tlbfr_cell.sv
// one slot of the age-ordered entry chain: holds a page/frame pair,
// compares it as the search token passes and hands its pair to the older neighbor
// depends on tlbfr_pkg
module tlbfr_cell import tlbfr_pkg::*; #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_mode          i_mode,
    input  t_pair          i_new,
    input  logic [CW-1:0]  i_count,
    input  logic           i_wr,
    input  logic [IW-1:0]  i_wr_idx,
    input  t_link          i_link,
    output t_link          o_link,
    input  t_pair          i_nbr,
    input  logic           i_nbr_give,
    output t_pair          o_pair,
    output logic           o_give
);

    t_pair               r_pair;
    t_pair               n_pair;
    logic                r_tok;
    logic                r_found;
    logic                n_found;
    logic [FRAME_W-1:0]  r_frame;
    logic [FRAME_W-1:0]  n_frame;
    logic                valid;
    logic                match;

    assign valid  = CW'(IDX) < i_count;
    assign match  = valid && (i_mode.match_all ||
                              (i_mode.match_page && (r_pair.page == i_new.page)));
    assign o_give = i_link.tok && i_link.found && valid && i_mode.shift;

    always_comb begin
        n_found = i_link.found || match;
        n_frame = match ? r_pair.frame : i_link.frame;
        if (i_nbr_give) begin
            n_pair = i_nbr;
        end else if (i_wr && (i_wr_idx == IW'(IDX))) begin
            n_pair = i_new;
        end else begin
            n_pair = r_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_link.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair  <= n_pair;
        r_found <= n_found;
        r_frame <= n_frame;
    end

    assign o_pair       = r_pair;
    assign o_link.tok   = r_tok;
    assign o_link.found = r_found;
    assign o_link.frame = r_frame;

endmodule

// File: hdl/tlb_fifo_replace_lookup_unit.sv
// channel   | dir | handshake     | payload
// i_in      | in  | valid / ready | operation, page_number, frame_number
// o_out     | out | valid / ready | hit, frame_out, occupancy
//
// one request at a time: an accept step, a sweep while the search token walks the
// cell chain, then a commit step; the next request is taken only after the commit
// a response waiting in the output register does not block the next request,
// but the commit waits until that register is free
// synchronous active-low reset clears the entry count and the control flops
// fully associative translation buffer with fifo replacement
// depends on tlbfr_pkg, tlbfr_if and tlbfr_cell
module tlb_fifo_replace_lookup_unit import tlbfr_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tlbfr_in_if.sink        i_in,
    tlbfr_out_if.source     o_out
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SWEEP  = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic                r_start;
    logic [OP_W-1:0]     r_op;
    t_pair               r_new;
    t_mode               r_mode;
    t_mode               n_mode;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_res_hit;
    logic [FRAME_W-1:0]  r_res_frame;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                r_out_hit;
    logic [FRAME_W-1:0]  r_out_frame;
    logic [OCC_W-1:0]    r_out_occ;

    logic                accept;
    logic                commit;
    logic                full;
    logic                wr;
    logic [IW-1:0]       wr_idx;
    logic                res_hit;

    t_link               links [0:ENTRIES];
    t_pair               pairs [0:ENTRIES];
    logic                gives [0:ENTRIES];

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign commit     = (r_state == S_COMMIT) && (!r_out_valid || o_out.ready);
    assign full       = (r_count == CW'(ENTRIES));

    assign links[0].tok   = r_start;
    assign links[0].found = 1'b0;
    assign links[0].frame = '0;
    assign pairs[ENTRIES] = '0;
    assign gives[ENTRIES] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tlbfr_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_mode     (r_mode),
            .i_new      (r_new),
            .i_count    (r_count),
            .i_wr       (wr),
            .i_wr_idx   (wr_idx),
            .i_link     (links[g]),
            .o_link     (links[g+1]),
            .i_nbr      (pairs[g+1]),
            .i_nbr_give (gives[g+1]),
            .o_pair     (pairs[g]),
            .o_give     (gives[g])
        );
    end

    always_comb begin
        n_mode = '0;
        case (i_in.operation)
            OP_LOOKUP: begin
                n_mode.match_page = 1'b1;
            end
            OP_ADD: begin
                n_mode.match_all = full;
                n_mode.shift     = full;
            end
            OP_UPDATE: begin
                n_mode.match_page = 1'b1;
                n_mode.shift      = 1'b1;
            end
            default: begin
                n_mode = '0;
            end
        endcase
    end

    always_comb begin
        wr      = 1'b0;
        wr_idx  = IW'(r_count - CW'(1));
        n_count = r_count;
        res_hit = 1'b0;
        case (r_op)
            OP_LOOKUP: begin
                res_hit = r_res_hit;
            end
            OP_ADD: begin
                wr     = commit;
                wr_idx = full ? IW'(ENTRIES - 1) : IW'(r_count);
                if (commit && !full) begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_UPDATE: begin
                wr      = commit && (r_count != '0);
                res_hit = r_res_hit;
            end
            default: begin
                wr = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (links[ENTRIES].tok) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= accept;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= i_in.operation;
            r_new.page  <= i_in.page_number;
            r_new.frame <= i_in.frame_number;
        end
        if ((r_state == S_SWEEP) && links[ENTRIES].tok) begin
            r_res_hit   <= links[ENTRIES].found;
            r_res_frame <= links[ENTRIES].frame;
        end
        if (commit) begin
            r_out_hit   <= res_hit;
            r_out_frame <= ((r_op == OP_LOOKUP) && r_res_hit) ? r_res_frame : '0;
            r_out_occ   <= OCC_W'(n_count);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.hit       = r_out_hit;
    assign o_out.frame_out = r_out_frame;
    assign o_out.occupancy = r_out_occ;

endmodule

// File: hdl/tlbfr_chk.sv
// port-level checks for the translation buffer, bound to the top level
// depends on tlbfr_pkg and tlb_fifo_replace_lookup_unit
module tlbfr_chk import tlbfr_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_hit,
    input logic [FRAME_W-1:0]  i_frame_out,
    input logic [OCC_W-1:0]    i_occupancy
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while previous item in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_hit, i_frame_out, i_occupancy}))
        else $error("response changed while stalled");

    a_miss_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> i_frame_out == '0)
        else $error("nonzero frame on a miss");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (ENTRIES >= 32) || (i_occupancy <= OCC_W'(ENTRIES)))
        else $error("occupancy above capacity");

endmodule

bind tlb_fifo_replace_lookup_unit tlbfr_chk #(
    .ENTRIES (ENTRIES)
) u_tlbfr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hit       (o_out.hit),
    .i_frame_out (o_out.frame_out),
    .i_occupancy (o_out.occupancy)
);
